// ===== design/tcu_pkg.sv =====
// ----------------------------------------------------------------------------
// tcu_pkg
// Shared types, operation codes and base-3 helpers for the cube unit.
// ----------------------------------------------------------------------------
package tcu_pkg;

    typedef enum logic [2:0] {
        OP_FEWER_ONES = 3'd0,
        OP_COMBINABLE = 3'd1,
        OP_MERGE      = 3'd2,
        OP_COVERS     = 3'd3,
        OP_MARK       = 3'd4,
        OP_IS_MARKED  = 3'd5
    } op_t;

    localparam int CUBE_W  = 32;
    localparam int COUNT_W = 5;

    typedef struct packed {
        logic [2:0]         op;
        logic [CUBE_W-1:0]  rem1;
        logic [CUBE_W-1:0]  rem2;
        logic [CUBE_W-1:0]  acc;
        logic [COUNT_W-1:0] ones1;
        logic [COUNT_W-1:0] ones2;
        logic               dash_bad;
        logic               cover_bad;
        logic [1:0]         diffs;
        logic [CUBE_W-1:0]  mark_cube;
        logic               marked;
    } stage_t;

    function automatic logic [CUBE_W-1:0] pow3(input int n);
        logic [CUBE_W-1:0] p;
        p = 32'd1;
        for (int k = 0; k < n; k++) begin
            p = CUBE_W'(p * 32'd3);
        end
        return p;
    endfunction

endpackage

// ===== design/tcu_split.sv =====
// ----------------------------------------------------------------------------
// tcu_split
// Splits the first cube into mark and body and takes the body (value mod 3^N) of the second, over three stages.
// ----------------------------------------------------------------------------
module tcu_split #(
    parameter int NUM_TRITS = 19
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [2:0]                op,
    input  logic [tcu_pkg::CUBE_W-1:0] c1,
    input  logic [tcu_pkg::CUBE_W-1:0] c2,
    output logic                      out_valid,
    output tcu_pkg::stage_t           out_stage
);

    localparam logic [31:0] WEIGHT = tcu_pkg::pow3(NUM_TRITS);
    localparam logic [63:0] RECIP64 = 64'h1_0000_0000 / {32'd0, WEIGHT};
    localparam logic [31:0] RECIP = RECIP64[31:0];

    logic        va_reg, vb_reg, vc_reg;
    logic [2:0]  opa_reg, opb_reg;
    logic [31:0] c1a_reg, c2a_reg, q1a_reg, q2a_reg;
    logic [31:0] r1b_reg, r2b_reg;
    logic [31:0] mca_reg, mcb_reg;
    logic        mka_reg, mkb_reg;
    tcu_pkg::stage_t st_reg, st_next;

    logic [63:0] p1, p2, m1, m2;

    always_comb begin
        p1 = {32'd0, c1} * {32'd0, RECIP};
        p2 = {32'd0, c2} * {32'd0, RECIP};
        m1 = {32'd0, q1a_reg} * {32'd0, WEIGHT};
        m2 = {32'd0, q2a_reg} * {32'd0, WEIGHT};
    end

    always_comb begin
        st_next           = '0;
        st_next.op        = opb_reg;
        st_next.rem1      = (r1b_reg >= WEIGHT) ? r1b_reg - WEIGHT : r1b_reg;
        st_next.rem2      = (r2b_reg >= WEIGHT) ? r2b_reg - WEIGHT : r2b_reg;
        st_next.mark_cube = mcb_reg;
        st_next.marked    = mkb_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
        if (en) begin
            opa_reg <= op;
            c1a_reg <= c1;
            c2a_reg <= c2;
            q1a_reg <= p1[63:32];
            q2a_reg <= p2[63:32];
            mka_reg <= (c1 >= WEIGHT);
            mca_reg <= (c1 >= WEIGHT) ? c1 : c1 + WEIGHT;
            opb_reg <= opa_reg;
            r1b_reg <= c1a_reg - m1[31:0];
            r2b_reg <= c2a_reg - m2[31:0];
            mkb_reg <= mka_reg;
            mcb_reg <= mca_reg;
            st_reg  <= st_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_stage = st_reg;

endmodule

// ===== design/tcu_digit_stage.sv =====
// ----------------------------------------------------------------------------
// tcu_digit_stage
// Peels a group of trits from the top of both bodies and folds them into the
// running counts, flags and merged cube.
// ----------------------------------------------------------------------------
module tcu_digit_stage #(
    parameter int FIRST = 18,
    parameter int COUNT = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  tcu_pkg::stage_t in_stage,
    output logic            out_valid,
    output tcu_pkg::stage_t out_stage
);

    logic            v_reg;
    tcu_pkg::stage_t st_reg, st_next;

    always_comb begin
        logic [31:0] x1, x2, p;
        logic [1:0]  d1, d2;
        st_next = in_stage;
        x1 = in_stage.rem1;
        x2 = in_stage.rem2;
        for (int j = 0; j < COUNT; j++) begin
            p = tcu_pkg::pow3(FIRST - j);
            if (x1 >= {p[30:0], 1'b0}) begin
                d1 = 2'd2;
                x1 = x1 - {p[30:0], 1'b0};
            end else if (x1 >= p) begin
                d1 = 2'd1;
                x1 = x1 - p;
            end else begin
                d1 = 2'd0;
            end
            if (x2 >= {p[30:0], 1'b0}) begin
                d2 = 2'd2;
                x2 = x2 - {p[30:0], 1'b0};
            end else if (x2 >= p) begin
                d2 = 2'd1;
                x2 = x2 - p;
            end else begin
                d2 = 2'd0;
            end
            if (d1 == 2'd1) st_next.ones1 = st_next.ones1 + 5'd1;
            if (d2 == 2'd1) st_next.ones2 = st_next.ones2 + 5'd1;
            if (d1 != d2) begin
                st_next.acc = st_next.acc + {p[30:0], 1'b0};
                if (d1 == 2'd2 || d2 == 2'd2) begin
                    st_next.dash_bad = 1'b1;
                end else if (st_next.diffs != 2'd2) begin
                    st_next.diffs = st_next.diffs + 2'd1;
                end
                if (d2 != 2'd2) st_next.cover_bad = 1'b1;
            end else if (d1 == 2'd2) begin
                st_next.acc = st_next.acc + {p[30:0], 1'b0};
            end else if (d1 == 2'd1) begin
                st_next.acc = st_next.acc + p;
            end
        end
        st_next.rem1 = x1;
        st_next.rem2 = x2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = v_reg;
    assign out_stage = st_reg;

endmodule

// ===== design/ternary_cube_operation_unit.sv =====
// ----------------------------------------------------------------------------
// ternary_cube_operation_unit
// Product-term cube operations on base-3 packed cubes.
// ----------------------------------------------------------------------------
// One word is taken every cycle while the output side keeps up. The pipeline
// is made of the split stages, which strip the mark with a reciprocal multiply,
// one stage per group of four trits peeled from the top, and the output
// register. The whole pipeline holds while a result waits and m_axis_tready
// is low.
module ternary_cube_operation_unit #(
    parameter int NUM_TRITS = 19
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // operation[2:0], first_cube, second_cube, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // result_cube[31:0], result_flag, pad
);

    localparam int DPS  = 4;
    localparam int NSTG = (NUM_TRITS + DPS - 1) / DPS;

    logic            en;
    logic            v    [NSTG+1];
    tcu_pkg::stage_t pipe [NSTG+1];

    logic        out_valid_reg;
    logic [31:0] cube_reg, cube_next;
    logic        flag_reg, flag_next;

    assign en = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    tcu_split #(.NUM_TRITS(NUM_TRITS)) u_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .op        (s_axis_tdata[2:0]),
        .c1        (s_axis_tdata[34:3]),
        .c2        (s_axis_tdata[66:35]),
        .out_valid (v[0]),
        .out_stage (pipe[0])
    );

    for (genvar s = 0; s < NSTG; s++) begin : g_digit
        localparam int LEFT = NUM_TRITS - s * DPS;
        tcu_digit_stage #(
            .FIRST (LEFT - 1),
            .COUNT ((LEFT < DPS) ? LEFT : DPS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v[s]),
            .in_stage  (pipe[s]),
            .out_valid (v[s+1]),
            .out_stage (pipe[s+1])
        );
    end

    always_comb begin
        cube_next = 32'd0;
        flag_next = 1'b0;
        unique case (pipe[NSTG].op)
            tcu_pkg::OP_FEWER_ONES: flag_next = pipe[NSTG].ones1 < pipe[NSTG].ones2;
            tcu_pkg::OP_COMBINABLE:
                flag_next = !pipe[NSTG].dash_bad && (pipe[NSTG].diffs != 2'd2);
            tcu_pkg::OP_MERGE:      cube_next = pipe[NSTG].acc;
            tcu_pkg::OP_COVERS:     flag_next = !pipe[NSTG].cover_bad;
            tcu_pkg::OP_MARK:       cube_next = pipe[NSTG].mark_cube;
            tcu_pkg::OP_IS_MARKED:  flag_next = pipe[NSTG].marked;
            default: begin
                cube_next = 32'd0;
                flag_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v[NSTG];
        end
        if (en) begin
            cube_reg <= cube_next;
            flag_reg <= flag_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, flag_reg, cube_reg};

endmodule

// ===== sim/tcu_checker.sv =====
// ----------------------------------------------------------------------------
// tcu_checker
// Watches both stream channels of the cube unit, predicts each result from
// the accepted input word and compares it field by field, oldest first.
// ----------------------------------------------------------------------------
module tcu_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);

    localparam int TRITS = 19;
    localparam longint unsigned MARK_WEIGHT = 64'd1162261467;

    typedef struct packed {
        logic [31:0] cube;
        logic        flag;
    } cube_result_t;

    cube_result_t awaited_results[$];

    function automatic cube_result_t cube_op_predict(logic [2:0] opc, logic [31:0] c1,
                                                     logic [31:0] c2);
        cube_result_t r;
        longint unsigned b1, b2, w, acc;
        int ones1, ones2, diffs, da, db;
        bit dash_ok, cover_ok;
        r = '0;
        b1 = c1 % MARK_WEIGHT;
        b2 = c2 % MARK_WEIGHT;
        ones1 = 0; ones2 = 0; diffs = 0;
        dash_ok = 1; cover_ok = 1;
        acc = 0; w = 1;
        for (int k = 0; k < TRITS; k++) begin
            da = int'(b1 % 3);
            db = int'(b2 % 3);
            if (da == 1) ones1++;
            if (db == 1) ones2++;
            if (da == 2 || db == 2) begin
                if (da != db) dash_ok = 0;
            end else if (da != db) begin
                diffs++;
            end
            if (da != db && db != 2) cover_ok = 0;
            acc += (da == db ? da : 2) * w;
            w *= 3;
            b1 /= 3;
            b2 /= 3;
        end
        case (opc)
            tcu_pkg::OP_FEWER_ONES: r.flag = ones1 < ones2;
            tcu_pkg::OP_COMBINABLE: r.flag = dash_ok && diffs <= 1;
            tcu_pkg::OP_MERGE:      r.cube = acc[31:0];
            tcu_pkg::OP_COVERS:     r.flag = cover_ok;
            tcu_pkg::OP_MARK:
                r.cube = (c1 / MARK_WEIGHT == 0) ? c1 + 32'(MARK_WEIGHT) : c1;
            tcu_pkg::OP_IS_MARKED:  r.flag = (c1 / MARK_WEIGHT) != 0;
            default:                r = '0;
        endcase
        return r;
    endfunction

    assign pending_count = awaited_results.size();

    always @(posedge aclk) begin
        cube_result_t exp_r;
        if (!aresetn) begin
            fail_count   <= 0;
            result_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(cube_op_predict(s_axis_tdata[2:0],
                    s_axis_tdata[34:3], s_axis_tdata[66:35]));
            if (m_axis_tvalid && m_axis_tready) begin
                result_count <= result_count + 1;
                if (awaited_results.size() == 0) begin
                    $error("unexpected result word %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (m_axis_tdata[31:0] !== exp_r.cube) begin
                        $error("result_cube expected %0d actual %0d", exp_r.cube,
                               m_axis_tdata[31:0]);
                        fail_count <= fail_count + 1;
                    end else if (m_axis_tdata[32] !== exp_r.flag) begin
                        $error("result_flag expected %0d actual %0d", exp_r.flag,
                               m_axis_tdata[32]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the cube unit: directed corner cubes for every operation,
// then random and structured cube pairs under three back-pressure regimes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam longint unsigned MARK_WEIGHT = 64'd1162261467;
    localparam longint unsigned CUBE_MAX    = 64'd2324522933;
    localparam int LATENCY     = 9;
    localparam int STALL_LIMIT = 5000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;  // operation, first_cube, second_cube, pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;       // result_cube, result_flag, pad

    int fail_count, pending_count, result_count;
    int send_idle_pct = 0, recv_idle_pct = 0;
    int idle_cycles = 0;
    int items_sent = 0;

    always #5 aclk = ~aclk;

    ternary_cube_operation_unit dut (.*);

    tcu_checker u_checker (.*);

    always @(posedge aclk) begin
        if (aresetn)
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] trit_cube(int dash_pct, bit marked);
        longint unsigned v, w;
        int t;
        v = 0; w = 1;
        for (int k = 0; k < 19; k++) begin
            t = ($urandom_range(99) < dash_pct) ? 2 : $urandom_range(1);
            v += t * w;
            w *= 3;
        end
        if (marked) v += MARK_WEIGHT;
        return v[31:0];
    endfunction

    // flip one randomly picked trit between 0 and 1; a dash picked is left unchanged
    function automatic logic [31:0] flip_trit(logic [31:0] c);
        longint unsigned w;
        int k, d;
        k = $urandom_range(18);
        w = 1;
        for (int j = 0; j < k; j++) w *= 3;
        d = int'((c / w) % 3);
        if (d == 0) return c + 32'(w);
        if (d == 1) return c - 32'(w);
        return c;
    endfunction

    task automatic send_word(logic [2:0] opc, logic [31:0] c1, logic [31:0] c2);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {5'd0, c2, c1, opc};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 0;
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic random_word;
        logic [2:0]  opc;
        logic [31:0] c1, c2;
        int kind;
        opc  = 3'($urandom_range(7));
        kind = $urandom_range(9);
        c1 = trit_cube($urandom_range(60), $urandom_range(3) == 0);
        case (kind)
            0, 1:    c2 = c1;
            2, 3, 4: c2 = flip_trit(c1);
            5:       c2 = flip_trit(flip_trit(c1));
            6:       c2 = trit_cube($urandom_range(60), 1'($urandom_range(1)));
            7: begin
                c1 = 32'($urandom_range(32'(CUBE_MAX)));
                c2 = 32'($urandom_range(32'(CUBE_MAX)));
            end
            default: c2 = (c1 % 32'(MARK_WEIGHT)) + ($urandom_range(1) ? 32'(MARK_WEIGHT) : 0);
        endcase
        if (kind == 8 && $urandom_range(1)) c2 = flip_trit(c2);
        send_word(opc, c1, c2);
    endtask

    localparam logic [31:0] ALL_ONES_BODY = 32'd581130733;
    localparam logic [31:0] ALL_DASH_BODY = 32'(MARK_WEIGHT - 1);

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_idle_pct = 20;
        recv_idle_pct = 83;

        // corners: zero cube, all ones, all dashes, marks 1 and 2, top value
        for (int o = 0; o < 8; o++)
            send_word(o[2:0], 32'd0, ALL_ONES_BODY);
        send_word(tcu_pkg::OP_FEWER_ONES, ALL_ONES_BODY, 32'd0);
        send_word(tcu_pkg::OP_COMBINABLE, ALL_DASH_BODY, ALL_DASH_BODY);
        send_word(tcu_pkg::OP_COMBINABLE, 32'd0, 32'd1);
        send_word(tcu_pkg::OP_COMBINABLE, 32'd0, 32'd4);
        send_word(tcu_pkg::OP_COMBINABLE, 32'd0, 32'd2);
        send_word(tcu_pkg::OP_MERGE, ALL_DASH_BODY + 32'(MARK_WEIGHT), 32'd0);
        send_word(tcu_pkg::OP_COVERS, 32'd0, ALL_DASH_BODY);
        send_word(tcu_pkg::OP_COVERS, ALL_DASH_BODY, 32'd0);
        send_word(tcu_pkg::OP_COVERS, 32'(MARK_WEIGHT), 32'(2 * MARK_WEIGHT));
        send_word(tcu_pkg::OP_MARK, 32'(MARK_WEIGHT), 32'hFFFF_FFFF);
        send_word(tcu_pkg::OP_MARK, 32'(CUBE_MAX), 32'd0);
        send_word(tcu_pkg::OP_MARK, ALL_DASH_BODY, 32'd0);
        send_word(tcu_pkg::OP_IS_MARKED, 32'(CUBE_MAX), 32'd0);
        send_word(tcu_pkg::OP_IS_MARKED, ALL_DASH_BODY, 32'd0);
        send_word(tcu_pkg::OP_FEWER_ONES, 32'(CUBE_MAX), 32'hFFFF_FFFF);
        send_word(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        drain;
        for (int i = 0; i < 620; i++) random_word;
        drain;
        send_idle_pct = 83;
        recv_idle_pct = 20;
        for (int i = 0; i < 620; i++) random_word;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 690; i++) random_word;

        drain;
        repeat (LATENCY * 4) @(posedge aclk);
        $display("Sent %0d words over all six operations, unused codes and marked cubes;",
                 items_sent);
        $display("checked %0d results under three idling regimes.", result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
